FILE: rtl/hmf_pkg.sv
// shared constants, name table and inter-module types for the http message framer
package hmf_pkg;

	localparam int BUFFER_BYTES = 4096;
	localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
	localparam int CNT_W        = LEN_W;
	localparam int NAME_LEN     = 15;

	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(BUFFER_BYTES);
	localparam logic [4:0]       NO_MATCH = 5'd16;

	// content-length value scan phases
	localparam logic [1:0] PH_SEEK   = 2'd0;
	localparam logic [1:0] PH_BLANK  = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	function automatic logic [7:0] name_char(input logic [3:0] idx);
		case (idx)
			4'd0:    name_char = "c";
			4'd1:    name_char = "o";
			4'd2:    name_char = "n";
			4'd3:    name_char = "t";
			4'd4:    name_char = "e";
			4'd5:    name_char = "n";
			4'd6:    name_char = "t";
			4'd7:    name_char = "-";
			4'd8:    name_char = "l";
			4'd9:    name_char = "e";
			4'd10:   name_char = "n";
			4'd11:   name_char = "g";
			4'd12:   name_char = "t";
			4'd13:   name_char = "h";
			4'd14:   name_char = ":";
			default: name_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		lower_ascii = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	typedef struct packed {
		logic step;
		logic new_conn;
		logic active;
		logic clear;
	} hmf_ctrl_t;

	typedef struct packed {
		logic             hdone;
		logic [LEN_W-1:0] acc_cur;
		logic [LEN_W-1:0] acc_nxt;
	} hmf_status_t;

endpackage

FILE: rtl/hmf_in_stage.sv
// input register stage of the http message framer
module hmf_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       new_connection,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       newconn_s1
);
	import hmf_pkg::*;

	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1    <= data_byte;
			newconn_s1 <= new_connection;
		end
	end

endmodule

FILE: rtl/hmf_header_scan.sv
// header parse state: terminator search, content-length name match and value scan
module hmf_header_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_s1,
	input  hmf_pkg::hmf_ctrl_t  ctrl,
	output hmf_pkg::hmf_status_t status
);
	import hmf_pkg::*;

	logic [1:0]       term_q, term_cur, term_nxt;
	logic [4:0]       match_q, match_cur, match_nxt, match_inc;
	logic [1:0]       phase_q, phase_cur, phase_nxt, phase_scan;
	logic             found_q, found_cur, found_nxt;
	logic [LEN_W-1:0] acc_q, acc_cur, acc_nxt;
	logic [LEN_W+3:0] acc_ten;
	logic             is_digit, is_blank, hdone;
	logic [7:0]       lower;

	// a new connection clears everything before its first byte is parsed
	assign term_cur  = ctrl.new_conn ? 2'd0 : term_q;
	assign match_cur = ctrl.new_conn ? 5'd0 : match_q;
	assign phase_cur = ctrl.new_conn ? PH_SEEK : phase_q;
	assign found_cur = ctrl.new_conn ? 1'b0 : found_q;
	assign acc_cur   = ctrl.new_conn ? '0 : acc_q;

	assign is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_blank  = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);
	assign lower     = lower_ascii(byte_s1);
	assign match_inc = match_cur + 5'd1;
	assign acc_ten   = ({4'b0, acc_cur} << 3) + ({4'b0, acc_cur} << 1)
		+ {{LEN_W{1'b0}}, byte_s1[3:0]};

	always_comb begin
		match_nxt  = match_cur;
		phase_nxt  = phase_cur;
		phase_scan = phase_cur;
		found_nxt  = found_cur;
		acc_nxt    = acc_cur;
		if (phase_cur == PH_BLANK || phase_cur == PH_DIGITS) begin
			if (phase_cur == PH_BLANK) begin
				if (!is_blank) begin
					phase_scan = is_digit ? PH_DIGITS : PH_DONE;
				end
			end else if (!is_digit) begin
				phase_scan = PH_DONE;
			end
			if (phase_scan == PH_DIGITS) begin
				acc_nxt = (acc_ten > (LEN_W+4)'(BUFFER_BYTES)) ? LEN_MAX : acc_ten[LEN_W-1:0];
			end
			phase_nxt = phase_scan;
		end else begin
			if (!found_cur && match_cur < 5'(NAME_LEN)) begin
				if (lower == name_char(match_cur[3:0])) begin
					match_nxt = match_inc;
					if (match_inc == 5'(NAME_LEN)) begin
						found_nxt = 1'b1;
						phase_nxt = PH_BLANK;
					end
				end else begin
					match_nxt = NO_MATCH;
				end
			end else if (match_cur < 5'(NAME_LEN)) begin
				match_nxt = NO_MATCH;
			end
		end
		if (byte_s1 == CH_LF) begin
			match_nxt = 5'd0;
		end
	end

	always_comb begin
		hdone    = 1'b0;
		term_nxt = 2'd0;
		if (byte_s1 == CH_CR) begin
			term_nxt = (term_cur == 2'd2) ? 2'd3 : 2'd1;
		end else if (byte_s1 == CH_LF && term_cur == 2'd1) begin
			term_nxt = 2'd2;
		end else if (byte_s1 == CH_LF && term_cur == 2'd3) begin
			term_nxt = 2'd3;
			hdone    = 1'b1;
		end
	end

	assign status.hdone   = hdone;
	assign status.acc_cur = acc_cur;
	assign status.acc_nxt = acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q  <= 2'd0;
			match_q <= 5'd0;
			phase_q <= PH_SEEK;
			found_q <= 1'b0;
			acc_q   <= '0;
		end else if (ctrl.step) begin
			if (ctrl.clear) begin
				term_q  <= 2'd0;
				match_q <= 5'd0;
				phase_q <= PH_SEEK;
				found_q <= 1'b0;
				acc_q   <= '0;
			end else if (ctrl.active) begin
				term_q  <= hdone ? 2'd0 : term_nxt;
				match_q <= match_nxt;
				phase_q <= phase_nxt;
				found_q <= found_nxt;
				acc_q   <= acc_nxt;
			end else begin
				term_q  <= term_cur;
				match_q <= match_cur;
				phase_q <= phase_cur;
				found_q <= found_cur;
				acc_q   <= acc_cur;
			end
		end
	end

endmodule

FILE: rtl/hmf_msg_ctrl.sv
// message framing control: byte count, body countdown, error flag and result register
module hmf_msg_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  logic [7:0]                 byte_s1,
	input  logic                       newconn_s1,
	input  hmf_pkg::hmf_status_t       status,
	output hmf_pkg::hmf_ctrl_t         ctrl,
	output logic                       adv,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 byte_out,
	output logic                       in_body,
	output logic                       header_done,
	output logic                       message_end,
	output logic [hmf_pkg::LEN_W-1:0]  body_length,
	output logic                       framing_error
);
	import hmf_pkg::*;

	logic             err_q, err_cur, err_n, over;
	logic [CNT_W-1:0] cnt_q, cnt_cur, cnt_inc, cnt_n;
	logic             body_q, body_cur, body_n;
	logic [LEN_W-1:0] rem_q, rem_cur, rem_n;
	logic             step, r_body, r_hdone, r_mend, active, clear;
	logic [LEN_W-1:0] r_blen;

	logic             valid_s2, body_s2, hdone_s2, mend_s2, err_s2;
	logic [7:0]       byte_s2;
	logic [LEN_W-1:0] blen_s2;

	assign adv  = !valid_s2 || !out_stall;
	assign step = valid_s1 && adv;

	assign err_cur  = newconn_s1 ? 1'b0 : err_q;
	assign cnt_cur  = newconn_s1 ? '0 : cnt_q;
	assign body_cur = newconn_s1 ? 1'b0 : body_q;
	assign rem_cur  = newconn_s1 ? '0 : rem_q;

	assign cnt_inc = cnt_cur + CNT_W'(1);
	assign over    = !err_cur && (cnt_inc >= CNT_W'(BUFFER_BYTES));
	assign err_n   = err_cur || over;

	always_comb begin
		cnt_n   = err_cur ? cnt_cur : (over ? CNT_W'(BUFFER_BYTES) : cnt_inc);
		body_n  = body_cur;
		rem_n   = rem_cur;
		r_body  = 1'b0;
		r_hdone = 1'b0;
		r_mend  = 1'b0;
		r_blen  = status.acc_cur;
		active  = 1'b0;
		clear   = 1'b0;
		if (!err_n) begin
			if (body_cur) begin
				r_body = 1'b1;
				rem_n  = rem_cur - LEN_W'(1);
				if (rem_n == '0) begin
					r_mend = 1'b1;
					clear  = 1'b1;
				end
			end else begin
				active = 1'b1;
				r_blen = status.acc_nxt;
				if (status.hdone) begin
					r_hdone = 1'b1;
					if (status.acc_nxt == '0) begin
						r_mend = 1'b1;
						clear  = 1'b1;
					end else begin
						body_n = 1'b1;
						rem_n  = status.acc_nxt;
					end
				end
			end
		end
		if (clear) begin
			cnt_n  = '0;
			body_n = 1'b0;
			rem_n  = '0;
		end
	end

	assign ctrl.step     = step;
	assign ctrl.new_conn = newconn_s1;
	assign ctrl.active   = active;
	assign ctrl.clear    = clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= 1'b0;
			cnt_q  <= '0;
			body_q <= 1'b0;
			rem_q  <= '0;
		end else if (step) begin
			err_q  <= err_n;
			cnt_q  <= cnt_n;
			body_q <= body_n;
			rem_q  <= rem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			byte_s2  <= byte_s1;
			body_s2  <= r_body;
			hdone_s2 <= r_hdone;
			mend_s2  <= r_mend;
			blen_s2  <= r_blen;
			err_s2   <= err_n;
		end
	end

	assign out_valid     = valid_s2;
	assign byte_out      = byte_s2;
	assign in_body       = body_s2;
	assign header_done   = hdone_s2;
	assign message_end   = mend_s2;
	assign body_length   = blen_s2;
	assign framing_error = err_s2;

	// a body in progress always has bytes left to take
	a_body_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		body_q |-> rem_q != '0)
		else $error("body active with zero bytes remaining");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUFFER_BYTES))
		else $error("message byte count beyond buffer size");

	// error stays until a new connection arrives
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && err_q && !newconn_s1 |=> err_q)
		else $error("framing error dropped without new connection");

	a_no_end_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && framing_error |-> !message_end && !header_done && !in_body)
		else $error("framing marks raised while in error");

	a_hdone_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_done |-> !in_body)
		else $error("header done flagged on a body byte");

endmodule

FILE: rtl/http_message_framer.sv
// top level of the http message framer
//
// Splits one connection's byte stream into back-to-back HTTP/1.1 messages
// framed by the content-length header. Input channel: data_byte and
// new_connection with in_valid / in_stall; new_connection marks the first
// byte of a connection and clears all parse state and the error flag.
// Output channel: one result per input byte (byte_out, in_body, header_done,
// message_end, body_length, framing_error) with out_valid / out_stall.
// A transfer happens on a rising edge with valid high and stall low.
// A byte taken into the input register is parsed and loaded into the result
// register when that register is empty or being taken, after which out_valid
// is high. The block takes one byte per cycle while the receiver does not
// stall; the parse state update is a single pass of small logic.
// When the receiver stalls, the result register holds, the input register
// takes one more byte and in_stall stays high while both are full; no byte
// is dropped.
// Reset (arst_n low) empties both registers and puts the parser at the
// start of a header with no error.
module http_message_framer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                data_byte,
	input  logic                      new_connection,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                byte_out,
	output logic                      in_body,
	output logic                      header_done,
	output logic                      message_end,
	output logic [hmf_pkg::LEN_W-1:0] body_length,
	output logic                      framing_error
);
	import hmf_pkg::*;

	logic        adv, valid_s1, newconn_s1;
	logic [7:0]  byte_s1;
	hmf_ctrl_t   ctrl;
	hmf_status_t status;

	hmf_in_stage u_in_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.new_connection (new_connection),
		.adv            (adv),
		.valid_s1       (valid_s1),
		.byte_s1        (byte_s1),
		.newconn_s1     (newconn_s1)
	);

	hmf_header_scan u_header_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.ctrl    (ctrl),
		.status  (status)
	);

	hmf_msg_ctrl u_msg_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1),
		.newconn_s1    (newconn_s1),
		.status        (status),
		.ctrl          (ctrl),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_out      (byte_out),
		.in_body       (in_body),
		.header_done   (header_done),
		.message_end   (message_end),
		.body_length   (body_length),
		.framing_error (framing_error)
	);

endmodule

FILE: sim/tb_http_message_framer.sv
// self-checking testbench for the http message framer: byte-level framing predictor and scoreboard
`timescale 1ns / 100ps

module tb_http_message_framer;
	import hmf_pkg::*;

	typedef struct packed {
		logic [7:0]       data;
		logic             body;
		logic             hdone;
		logic             mend;
		logic [LEN_W-1:0] blen;
		logic             err;
	} frame_t;

	// mirrors the framing state and holds the results still owed by the block
	class framing_scoreboard;
		bit [1:0]       crlf_seen;
		bit [4:0]       name_pos;
		bit [1:0]       phase;
		bit             len_seen;
		bit [LEN_W-1:0] len_acc;
		bit             body_active;
		bit [LEN_W-1:0] body_left;
		int             msg_bytes;
		bit             sticky_err;
		frame_t         expected_q[$];
		int             mismatches;
		int             checked;
		int             hdr_ends;
		int             msg_ends;
		int             err_bytes;
		string          field_name = "content-length:";

		function void new_message();
			crlf_seen   = 2'd0;
			name_pos    = 5'd0;
			phase       = PH_SEEK;
			len_seen    = 1'b0;
			len_acc     = '0;
			body_active = 1'b0;
			body_left   = '0;
			msg_bytes   = 0;
		endfunction

		function void scan_value(bit [7:0] c);
			bit digit;
			int v;
			digit = (c >= CH_ZERO && c <= CH_NINE);
			if (phase == PH_BLANK) begin
				if (c == CH_SPACE || c == CH_TAB)
					return;
				phase = digit ? PH_DIGITS : PH_DONE;
			end else if (!digit) begin
				phase = PH_DONE;
			end
			if (phase == PH_DIGITS) begin
				v = int'(len_acc) * 10 + int'(c - CH_ZERO);
				len_acc = (v > BUFFER_BYTES) ? LEN_W'(BUFFER_BYTES) : LEN_W'(v);
			end
		endfunction

		function void scan_name(bit [7:0] c);
			bit [7:0] folded;
			folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
			if (!len_seen && name_pos < 5'(NAME_LEN)) begin
				if (folded == field_name[name_pos]) begin
					name_pos++;
					if (name_pos == 5'(NAME_LEN)) begin
						len_seen = 1'b1;
						phase    = PH_BLANK;
					end
				end else begin
					name_pos = NO_MATCH;
				end
			end else if (name_pos < 5'(NAME_LEN)) begin
				name_pos = NO_MATCH;
			end
			if (c == CH_LF)
				name_pos = 5'd0;
		endfunction

		function void note_byte(bit [7:0] c, bit nc);
			frame_t r;
			r = '0;
			r.data = c;
			if (nc) begin
				new_message();
				sticky_err = 1'b0;
			end
			if (!sticky_err) begin
				msg_bytes++;
				if (msg_bytes >= BUFFER_BYTES) begin
					msg_bytes  = BUFFER_BYTES;
					sticky_err = 1'b1;
				end
			end
			if (sticky_err) begin
				r.blen = len_acc;
			end else if (body_active) begin
				r.body = 1'b1;
				r.blen = len_acc;
				body_left--;
				if (body_left == 0) begin
					r.mend = 1'b1;
					new_message();
				end
			end else begin
				if (phase == PH_BLANK || phase == PH_DIGITS)
					scan_value(c);
				else
					scan_name(c);
				if (phase != PH_SEEK && c == CH_LF)
					name_pos = 5'd0;
				// blank line detection across cr lf cr lf
				if (c == CH_CR)
					crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
				else if (c == CH_LF && crlf_seen == 2'd1)
					crlf_seen = 2'd2;
				else if (c == CH_LF && crlf_seen == 2'd3)
					r.hdone = 1'b1;
				else
					crlf_seen = 2'd0;
				r.blen = len_acc;
				if (r.hdone) begin
					if (len_acc == 0) begin
						r.mend = 1'b1;
						new_message();
					end else begin
						crlf_seen   = 2'd0;
						body_active = 1'b1;
						body_left   = len_acc;
					end
				end
			end
			r.err = sticky_err;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		task compare(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
		endtask

		task check_result(frame_t got);
			frame_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result byte %02h with nothing outstanding", got.data));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			compare("byte_out", 32'(got.data), 32'(want.data));
			compare("in_body", 32'(got.body), 32'(want.body));
			compare("header_done", 32'(got.hdone), 32'(want.hdone));
			compare("message_end", 32'(got.mend), 32'(want.mend));
			compare("body_length", 32'(got.blen), 32'(want.blen));
			compare("framing_error", 32'(got.err), 32'(want.err));
			hdr_ends  += int'(want.hdone);
			msg_ends  += int'(want.mend);
			err_bytes += int'(want.err);
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       data_byte;
	logic             new_connection;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       byte_out;
	logic             in_body;
	logic             header_done;
	logic             message_end;
	logic [LEN_W-1:0] body_length;
	logic             framing_error;

	framing_scoreboard sb = new();

	logic [7:0] msg_q[$];
	int         items_sent;
	int         sender_idle_pct;
	int         stall_pct;
	int         hold_left;
	bit         take;
	frame_t     seen;

	http_message_framer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.new_connection (new_connection),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.byte_out       (byte_out),
		.in_body        (in_body),
		.header_done    (header_done),
		.message_end    (message_end),
		.body_length    (body_length),
		.framing_error  (framing_error)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// outputs are sampled mid-cycle, where nothing moves
	always begin
		@(negedge clk);
		take = arst_n && out_valid && !out_stall;
		seen = {byte_out, in_body, header_done, message_end, body_length, framing_error};
		@(posedge clk);
		if (take)
			sb.check_result(seen);
	end

	task automatic send_byte(logic [7:0] b, logic nc);
		bit stalled;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		new_connection <= nc;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		sb.note_byte(b, nc);
		items_sent++;
	endtask

	task automatic send_queue(bit fresh);
		foreach (msg_q[i])
			send_byte(msg_q[i], fresh && i == 0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void add_text(string s, bit mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && c >= "a" && c <= "z" && $urandom_range(1))
				c = c - 8'd32;
			msg_q.push_back(c);
		end
	endfunction

	function automatic void add_filler_line();
		case ($urandom_range(5))
			0: add_text("Host: a.b\r\n", 0);
			1: add_text(" content-length: 9\r\n", 1);
			2: add_text("X-Content-Length: 4\r\n", 1);
			3: add_text("content-type: text\r\n", 1);
			4: add_text("Content-Lengt: 3\r\n", 1);
			default: add_text("Accept: */*\r\n", 0);
		endcase
	endfunction

	function automatic int pick_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(200, 60);
		return $urandom_range(24, 0);
	endfunction

	// one message with random spelling of the length line, which may also be missing, malformed or oversized
	function automatic void build_message(int len, bit huge);
		int kind;
		msg_q.delete();
		case ($urandom_range(3))
			0:       add_text("GET /items HTTP/1.1\r\n", 0);
			1:       add_text("POST /x HTTP/1.1\r\n", 0);
			2:       add_text("PUT /y/z HTTP/1.1\r\n", 0);
			default: ;
		endcase
		repeat ($urandom_range(2))
			add_filler_line();
		kind = $urandom_range(9);
		if (huge) begin
			add_text("content-length: 123456\r\n", 1);
		end else if (kind == 0) begin
			len = 0;
		end else begin
			add_text("content-length:", 1);
			repeat ($urandom_range(2))
				msg_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
			if (kind == 1) begin
				len = 0;
				add_text("abc", 0);
			end else begin
				if (kind == 2)
					add_text("00", 0);
				add_text($sformatf("%0d", len), 0);
				if (kind == 3)
					add_text("x7", 0);
			end
			add_text("\r\n", 0);
			// a second length line must be ignored
			if ($urandom_range(3) == 0)
				add_text("Content-Length: 77\r\n", 1);
		end
		if ($urandom_range(3) == 0)
			add_filler_line();
		add_text("\r\n", 0);
		repeat (len)
			msg_q.push_back(8'($urandom()));
	endfunction

	function automatic void build_noise();
		msg_q.delete();
		repeat ($urandom_range(30, 3)) begin
			case ($urandom_range(4))
				0:       msg_q.push_back(CH_CR);
				1:       msg_q.push_back(CH_LF);
				2:       msg_q.push_back("c");
				default: msg_q.push_back(8'($urandom()));
			endcase
		end
	endfunction

	task automatic run_phase(int idle, int stall, int quota);
		int start;
		int pick;
		bit fresh;
		sender_idle_pct = idle;
		stall_pct       = stall;
		start           = items_sent;
		fresh           = 1'b1;
		while (items_sent - start < quota) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				build_message(pick_len(), 1'b0);
				send_queue(fresh || $urandom_range(15) == 0);
				fresh = 1'b0;
			end else if (pick < 88) begin
				// cut short, the next message opens a new connection
				build_message(pick_len(), 1'b0);
				repeat ($urandom_range(msg_q.size() - 1))
					void'(msg_q.pop_back());
				send_queue(fresh);
				fresh = 1'b1;
			end else begin
				build_noise();
				send_queue(fresh || $urandom_range(1));
				fresh = 1'b1;
			end
		end
		wait_drained();
	endtask

	initial begin
		int spin;
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		data_byte       <= 8'h00;
		new_connection  <= 1'b0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		hold_left       = 0;
		items_sent      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-body message opened by an all-ones byte, then a one-byte body
		msg_q.delete();
		msg_q.push_back(8'hff);
		add_text("\r\n\r\n", 0);
		send_queue(1'b1);
		msg_q.delete();
		add_text("Content-Length:\t1\r\n\r\n", 0);
		msg_q.push_back(8'h00);
		send_queue(1'b0);

		// long receiver hold-off while the sender keeps offering
		hold_left = 300;
		build_message(20, 1'b0);
		send_queue(1'b0);

		// saturated length, message runs past the buffer, then frozen bytes
		build_message(4110, 1'b1);
		add_text("\r\n\r\nzz", 0);
		send_queue(1'b1);
		wait_drained();

		run_phase(0, 0, 350);
		run_phase(65, 0, 350);
		run_phase(0, 65, 350);
		run_phase(24, 24, 350);

		spin = 0;
		while (sb.expected_q.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

		$display("covered %0d bytes over four idle/stall mixes, %0d results checked",
			items_sent, sb.checked);
		$display("%0d header ends, %0d message ends, %0d bytes under the sticky error",
			sb.hdr_ends, sb.msg_ends, sb.err_bytes);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
